/* hdl/sgcr_pkg.sv */
// Shared types, constants, font table and colour conversion for the glyph cell rasterizer.
`timescale 1ns / 1ps
package sgcr_pkg;

   localparam int SCREEN_WIDTH_DEF  = 480;
   localparam int SCREEN_HEIGHT_DEF = 320;
   localparam int MAX_SCALE_DEF     = 4;

   localparam int GLYPH_COLS  = 5;
   localparam int GLYPH_ROWS  = 7;
   localparam int CELL_COLS   = 6;
   localparam int MASK_W      = 24;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      CSR_SCALE = 2'd0,
      CSR_FORE  = 2'd1,
      CSR_BACK  = 2'd2
   } csr_index_type;

   // Row 0 is the top glyph row; bit 4 of a row is the leftmost dot.
   typedef logic [0:GLYPH_ROWS-1][GLYPH_COLS-1:0] glyph_type;

   typedef struct packed {
      glyph_type   glyph;
      logic [2:0]  mag;
      logic [4:0]  wid;
      logic [4:0]  hgt;
      logic [9:0]  x0;
      logic [9:0]  y0;
      logic [8:0]  span_end;
      logic [17:0] fg;
      logic [17:0] bg;
   } desc_type;

   localparam glyph_type QMARK_GLYPH = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04};

   function automatic glyph_type font_lookup(input logic [7:0] code);
      glyph_type g;
      case (code)
         8'd32:   g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00};
         8'd33:   g = {5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04};
         8'd37:   g = {5'h18, 5'h19, 5'h02, 5'h04, 5'h08, 5'h13, 5'h03};
         8'd40:   g = {5'h02, 5'h04, 5'h08, 5'h08, 5'h08, 5'h04, 5'h02};
         8'd41:   g = {5'h08, 5'h04, 5'h02, 5'h02, 5'h02, 5'h04, 5'h08};
         8'd43:   g = {5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00};
         8'd44:   g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h08};
         8'd45:   g = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
         8'd46:   g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C};
         8'd47:   g = {5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h00, 5'h00};
         8'd48:   g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
         8'd49:   g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
         8'd50:   g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
         8'd51:   g = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
         8'd52:   g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
         8'd53:   g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
         8'd54:   g = {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
         8'd55:   g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
         8'd56:   g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
         8'd57:   g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E};
         8'd58:   g = {5'h00, 5'h0C, 5'h0C, 5'h00, 5'h0C, 5'h0C, 5'h00};
         8'd61:   g = {5'h00, 5'h00, 5'h1F, 5'h00, 5'h1F, 5'h00, 5'h00};
         8'd65:   g = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
         8'd66:   g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
         8'd67:   g = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
         8'd68:   g = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
         8'd69:   g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
         8'd70:   g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
         8'd71:   g = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E};
         8'd72:   g = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
         8'd73:   g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
         8'd74:   g = {5'h01, 5'h01, 5'h01, 5'h01, 5'h11, 5'h11, 5'h0E};
         8'd75:   g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
         8'd76:   g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
         8'd77:   g = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
         8'd78:   g = {5'h11, 5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11};
         8'd79:   g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
         8'd80:   g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
         8'd81:   g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
         8'd82:   g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
         8'd83:   g = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
         8'd84:   g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
         8'd85:   g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
         8'd86:   g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
         8'd87:   g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
         8'd88:   g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
         8'd89:   g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
         8'd90:   g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
         8'd91:   g = {5'h0E, 5'h08, 5'h08, 5'h08, 5'h08, 5'h08, 5'h0E};
         8'd93:   g = {5'h0E, 5'h02, 5'h02, 5'h02, 5'h02, 5'h02, 5'h0E};
         8'd95:   g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1F};
         8'd97:   g = {5'h00, 5'h00, 5'h0E, 5'h01, 5'h0F, 5'h11, 5'h0F};
         8'd98:   g = {5'h10, 5'h10, 5'h16, 5'h19, 5'h11, 5'h11, 5'h1E};
         8'd99:   g = {5'h00, 5'h00, 5'h0E, 5'h10, 5'h10, 5'h10, 5'h0E};
         8'd100:  g = {5'h01, 5'h01, 5'h0D, 5'h13, 5'h11, 5'h11, 5'h0F};
         8'd101:  g = {5'h00, 5'h00, 5'h0E, 5'h11, 5'h1F, 5'h10, 5'h0E};
         8'd102:  g = {5'h06, 5'h09, 5'h08, 5'h1C, 5'h08, 5'h08, 5'h08};
         8'd103:  g = {5'h00, 5'h0F, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h0E};
         8'd104:  g = {5'h10, 5'h10, 5'h16, 5'h19, 5'h11, 5'h11, 5'h11};
         8'd105:  g = {5'h04, 5'h00, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h0E};
         8'd106:  g = {5'h02, 5'h00, 5'h06, 5'h02, 5'h02, 5'h12, 5'h0C};
         8'd107:  g = {5'h10, 5'h10, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12};
         8'd108:  g = {5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
         8'd109:  g = {5'h00, 5'h00, 5'h1A, 5'h15, 5'h15, 5'h15, 5'h15};
         8'd110:  g = {5'h00, 5'h00, 5'h16, 5'h19, 5'h11, 5'h11, 5'h11};
         8'd111:  g = {5'h00, 5'h00, 5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E};
         8'd112:  g = {5'h00, 5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10};
         8'd113:  g = {5'h00, 5'h0F, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01};
         8'd114:  g = {5'h00, 5'h00, 5'h16, 5'h19, 5'h10, 5'h10, 5'h10};
         8'd115:  g = {5'h00, 5'h00, 5'h0F, 5'h10, 5'h0E, 5'h01, 5'h1E};
         8'd116:  g = {5'h08, 5'h08, 5'h1C, 5'h08, 5'h08, 5'h09, 5'h06};
         8'd117:  g = {5'h00, 5'h00, 5'h11, 5'h11, 5'h11, 5'h13, 5'h0D};
         8'd118:  g = {5'h00, 5'h00, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
         8'd119:  g = {5'h00, 5'h00, 5'h11, 5'h11, 5'h15, 5'h15, 5'h0A};
         8'd120:  g = {5'h00, 5'h00, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11};
         8'd121:  g = {5'h00, 5'h00, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h0E};
         8'd122:  g = {5'h00, 5'h00, 5'h1F, 5'h02, 5'h04, 5'h08, 5'h1F};
         default: g = QMARK_GLYPH;
      endcase
      return g;
   endfunction

   // v * 255 / 31, top 6 bits; a 32-entry table.
   function automatic logic [5:0] chan5_to6(input logic [4:0] v);
      logic [5:0] r;
      r = '0;
      for (int i = 0; i < 32; i++) begin
         if (v == 5'(i)) r = 6'((i * 255 / 31) >> 2);
      end
      return r;
   endfunction

   // v * 255 / 63, top 6 bits; a 64-entry table.
   function automatic logic [5:0] chan6_to6(input logic [5:0] v);
      logic [5:0] r;
      r = '0;
      for (int i = 0; i < 64; i++) begin
         if (v == 6'(i)) r = 6'((i * 255 / 63) >> 2);
      end
      return r;
   endfunction

   function automatic logic [17:0] rgb565_to_666(input logic [15:0] c);
      return {chan5_to6(c[15:11]), chan6_to6(c[10:5]), chan5_to6(c[4:0])};
   endfunction

   // Stretch one glyph row by the magnification; the sixth cell column stays clear.
   function automatic logic [MASK_W-1:0] expand_row(input logic [GLYPH_COLS-1:0] bits,
                                                    input logic [2:0] mag);
      logic [MASK_W-1:0] m;
      int col;
      m = '0;
      for (int px = 0; px < MASK_W; px++) begin
         case (mag)
            3'd1:    col = px;
            3'd2:    col = px / 2;
            3'd3:    col = px / 3;
            default: col = px / 4;
         endcase
         if (col < GLYPH_COLS) m[px] = bits[GLYPH_COLS-1-col];
      end
      return m;
   endfunction

endpackage

/* hdl/sgcr_front.sv */
// Front end: configuration registers, word classification and cell setup.
`timescale 1ns / 1ps
module sgcr_front import sgcr_pkg::*; #(
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
   parameter int MAX_SCALE     = MAX_SCALE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_push,
   input  logic [7:0]  req_char_code,
   input  logic [9:0]  req_pos_x,
   input  logic [9:0]  req_pos_y,
   input  logic        q_full,
   output logic        q_push,
   output desc_type    q_desc
);

   localparam logic [10:0] SW_L   = 11'(SCREEN_WIDTH);
   localparam logic [10:0] SH_L   = 11'(SCREEN_HEIGHT);
   localparam logic [2:0]  MAXS_L = 3'(MAX_SCALE);

   logic [2:0]  scale_ff, scale_in;
   logic [15:0] fore_ff, fore_in;
   logic [15:0] back_ff, back_in;

   logic [2:0]  mag;
   logic [4:0]  wid_full, hgt_full, wid, hgt;
   logic [10:0] x_ext, y_ext, x_sum, y_sum, x_last;
   logic        visible;

   always_comb begin
      scale_in = scale_ff;
      fore_in  = fore_ff;
      back_in  = back_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_SCALE: scale_in = csr_wdata[2:0];
            CSR_FORE:  fore_in  = csr_wdata;
            CSR_BACK:  back_in  = csr_wdata;
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= 3'd1;
         fore_ff  <= 16'hFFFF;
         back_ff  <= 16'h0000;
      end else begin
         scale_ff <= scale_in;
         fore_ff  <= fore_in;
         back_ff  <= back_in;
      end
   end

   always_comb begin
      mag      = (scale_ff > MAXS_L) ? MAXS_L : scale_ff;
      wid_full = 5'({2'b00, mag} * 5'd6);
      hgt_full = 5'({2'b00, mag} * 5'd7);
      x_ext    = {1'b0, req_pos_x};
      y_ext    = {1'b0, req_pos_y};
      x_sum    = x_ext + 11'(wid_full);
      y_sum    = y_ext + 11'(hgt_full);
      // clip the cell at the right and bottom screen edges
      wid      = (x_sum > SW_L) ? 5'(SW_L - x_ext) : wid_full;
      hgt      = (y_sum > SH_L) ? 5'(SH_L - y_ext) : hgt_full;
      x_last   = x_ext + 11'(wid) - 11'd1;
      visible  = (scale_ff != 3'd0) && (x_ext < SW_L) && (y_ext < SH_L);
   end

   // drop words that draw nothing
   assign q_push = req_push && !q_full && visible;

   always_comb begin
      q_desc.glyph    = font_lookup(req_char_code);
      q_desc.mag      = mag;
      q_desc.wid      = wid;
      q_desc.hgt      = hgt;
      q_desc.x0       = req_pos_x;
      q_desc.y0       = req_pos_y;
      q_desc.span_end = x_last[8:0];
      q_desc.fg       = rgb565_to_666(fore_ff);
      q_desc.bg       = rgb565_to_666(back_ff);
   end

endmodule

/* hdl/sgcr_queue.sv */
// Short queue of cell descriptors between front and back end.
`timescale 1ns / 1ps
module sgcr_queue import sgcr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output desc_type head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   desc_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + CNT_W'(1);
      else if (do_pop && !do_push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_desc;
   end

endmodule

/* hdl/sgcr_back.sv */
// Back end: walks the rows of the head cell and holds one result word for the receiver.
`timescale 1ns / 1ps
module sgcr_back import sgcr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  desc_type    q_head,
   output logic        q_pop,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [8:0]  rsp_screen_row,
   output logic [8:0]  rsp_span_start,
   output logic [8:0]  rsp_span_end,
   output logic [23:0] rsp_pixel_mask,
   output logic [17:0] rsp_fore_rgb666,
   output logic [17:0] rsp_back_rgb666,
   output logic        rsp_last_row
);

   logic [4:0]  row_ff, row_in;     // screen row within the cell
   logic [1:0]  sub_ff, sub_in;     // repeat count of the current glyph row
   logic [2:0]  grow_ff, grow_in;   // glyph row
   logic        out_valid_ff, out_valid_in;

   logic [8:0]        screen_row_ff;
   logic [8:0]        span_start_ff;
   logic [8:0]        span_end_ff;
   logic [MASK_W-1:0] mask_ff;
   logic [17:0]       fg_ff, bg_ff;
   logic              last_ff;

   logic              emit, last;
   logic [MASK_W-1:0] wid_mask, row_mask;
   logic [9:0]        y_row;

   assign emit = !q_empty && (!out_valid_ff || rsp_pop);
   assign last = (row_ff == q_head.hgt - 5'd1);
   assign q_pop = emit && last;

   always_comb begin
      for (int px = 0; px < MASK_W; px++) begin
         wid_mask[px] = (5'(px) < q_head.wid);
      end
      row_mask = expand_row(q_head.glyph[grow_ff], q_head.mag) & wid_mask;
      y_row    = q_head.y0 + 10'(row_ff);
   end

   always_comb begin
      row_in       = row_ff;
      sub_in       = sub_ff;
      grow_in      = grow_ff;
      out_valid_in = out_valid_ff;
      if (rsp_pop) out_valid_in = 1'b0;
      if (emit) begin
         out_valid_in = 1'b1;
         if (last) begin
            row_in  = '0;
            sub_in  = '0;
            grow_in = '0;
         end else begin
            row_in = row_ff + 5'd1;
            // advance to the next glyph row once it has been repeated mag times
            if ({1'b0, sub_ff} == q_head.mag - 3'd1) begin
               sub_in  = '0;
               grow_in = grow_ff + 3'd1;
            end else begin
               sub_in = sub_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         sub_ff       <= '0;
         grow_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         sub_ff       <= sub_in;
         grow_ff      <= grow_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         screen_row_ff <= y_row[8:0];
         span_start_ff <= q_head.x0[8:0];
         span_end_ff   <= q_head.span_end;
         mask_ff       <= row_mask;
         fg_ff         <= q_head.fg;
         bg_ff         <= q_head.bg;
         last_ff       <= last;
      end
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_screen_row  = screen_row_ff;
   assign rsp_span_start  = span_start_ff;
   assign rsp_span_end    = span_end_ff;
   assign rsp_pixel_mask  = mask_ff;
   assign rsp_fore_rgb666 = fg_ff;
   assign rsp_back_rgb666 = bg_ff;
   assign rsp_last_row    = last_ff;

endmodule

/* hdl/scaled_glyph_cell_rasterizer.sv */
// Top level of the scaled 5x7 glyph cell rasterizer.
//
// Request side is a queue input: a word (char_code, pos_x, pos_y) is taken on a clock
// edge with req_push high and req_full low. Result side is a queue output: while
// rsp_empty is low the oldest row word sits on the rsp_ ports and rsp_pop takes it.
// Each character gives one word per drawn screen row, top to bottom, rsp_last_row
// marking the final one; off-screen cells and scale 0 give no words at all.
// The csr_ port writes scale_factor, fore_color and back_color on any edge with csr_we
// high; write it only while nothing is in flight.
// A taken word enters the descriptor queue, then its first row word is registered out.
// Throughput: one row word per cycle while the receiver keeps up; a cell gives one word
// per drawn row (up to 7 times the scale, at most 28), set by the back end's row walk over the head
// descriptor. A two-entry descriptor queue lets the front take further words while
// the back end draws; req_full rises when it is full.
// When the receiver stalls, the held row word waits and the row walk pauses with it.
// Reset (synchronous, active high) empties queue and output and restores the
// registers to scale 1, white foreground, black background.
`timescale 1ns / 1ps
module scaled_glyph_cell_rasterizer import sgcr_pkg::*; #(
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
   parameter int MAX_SCALE     = MAX_SCALE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_char_code,
   input  logic [9:0]  req_pos_x,
   input  logic [9:0]  req_pos_y,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [8:0]  rsp_screen_row,
   output logic [8:0]  rsp_span_start,
   output logic [8:0]  rsp_span_end,
   output logic [23:0] rsp_pixel_mask,
   output logic [17:0] rsp_fore_rgb666,
   output logic [17:0] rsp_back_rgb666,
   output logic        rsp_last_row
);

   logic     q_push, q_full, q_pop, q_empty;
   desc_type q_desc, q_head;

   assign req_full = q_full;

   sgcr_front #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .MAX_SCALE     (MAX_SCALE)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_push      (req_push),
      .req_char_code (req_char_code),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_desc        (q_desc)
   );

   sgcr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (q_desc),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   sgcr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_screen_row  (rsp_screen_row),
      .rsp_span_start  (rsp_span_start),
      .rsp_span_end    (rsp_span_end),
      .rsp_pixel_mask  (rsp_pixel_mask),
      .rsp_fore_rgb666 (rsp_fore_rgb666),
      .rsp_back_rgb666 (rsp_back_rgb666),
      .rsp_last_row    (rsp_last_row)
   );

endmodule
